>>> hw/rtl/mcf_pkg.sv
// Shared types, constants and coefficient tables of the candle flicker generator.
package mcf_pkg;

    // Filter coefficients, all unsigned Q0.32.
    typedef struct packed {
        logic [31:0] spring;
        logic [31:0] damping;
        logic [31:0] scale;
    } coef_t;

    // What the mode controller hands to the filters and the result path for one request.
    typedef struct packed {
        coef_t       fast;
        coef_t       slow;
        logic [2:0]  mode;
    } mode_out_t;

    // One result as it sits in the output buffer.
    typedef struct packed {
        logic [15:0] brightness;
        logic [2:0]  flicker_mode;
    } result_t;

    // Configuration register indexes.
    localparam logic [0:0] REG_HOLD_TICKS        = 1'b0;
    localparam logic [0:0] REG_BRIGHTNESS_OFFSET = 1'b1;

    localparam logic [15:0] HOLD_TICKS_RESET        = 16'd100;
    localparam logic [15:0] BRIGHTNESS_OFFSET_RESET = 16'd39322;

    // Number of rows and columns the transition table is laid out for.
    localparam int TABLE_DIM = 8;

    // Running sums of the transition weights along each row. A pick selects the first
    // column whose running sum exceeds it; a pick past the end of the row selects mode 0.
    localparam logic [6:0] TRANS_CUM [TABLE_DIM][TABLE_DIM] = '{
        '{7'd70, 7'd87, 7'd96, 7'd99, 7'd100, 7'd100, 7'd100, 7'd100},
        '{7'd30, 7'd85, 7'd95, 7'd99, 7'd100, 7'd100, 7'd100, 7'd100},
        '{7'd7,  7'd22, 7'd92, 7'd98, 7'd100, 7'd100, 7'd100, 7'd100},
        '{7'd7,  7'd25, 7'd45, 7'd95, 7'd100, 7'd100, 7'd100, 7'd100},
        '{7'd10, 7'd40, 7'd68, 7'd88, 7'd90,  7'd90,  7'd90,  7'd90},
        '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0,   7'd0,   7'd0},
        '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0,   7'd0,   7'd0},
        '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0,   7'd0,   7'd0}
    };

    // Fast filter coefficients per mode. Unused modes repeat the calm mode.
    function automatic coef_t fast_coef(input logic [2:0] mode);
        coef_t c;
        case (mode)
            3'd1:    c = '{spring: 32'd34359738,  damping: 32'd257698038, scale: 32'd1288490};
            3'd2:    c = '{spring: 32'd85899346,  damping: 32'd171798692, scale: 32'd4294967};
            3'd3:    c = '{spring: 32'd214748365, damping: 32'd85899346,  scale: 32'd8589935};
            3'd4:    c = '{spring: 32'd858993459, damping: 32'd42949673,  scale: 32'd42949673};
            default: c = '{spring: 32'd4294967,   damping: 32'd343597384, scale: 32'd0};
        endcase
        return c;
    endfunction

    // Slow filter coefficients per mode. Unused modes repeat the calm mode.
    function automatic coef_t slow_coef(input logic [2:0] mode);
        coef_t c;
        case (mode)
            3'd1:    c = '{spring: 32'd429497,  damping: 32'd42949673, scale: 32'd128849};
            3'd2:    c = '{spring: 32'd1288490, damping: 32'd42949673, scale: 32'd214748};
            3'd3:    c = '{spring: 32'd2147484, damping: 32'd42949673, scale: 32'd300648};
            3'd4:    c = '{spring: 32'd4294967, damping: 32'd42949673, scale: 32'd429497};
            default: c = '{spring: 32'd42950,   damping: 32'd42949673, scale: 32'd21475};
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/mcf_mode_ctrl.sv
// Tick counter, Markov mode register and coefficient selection.
module mcf_mode_ctrl #(
    parameter int MODE_COUNT = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [15:0]        hold_ticks,
    input  logic [6:0]         uniform_pick,
    output mcf_pkg::mode_out_t mode_out
);
    import mcf_pkg::*;

    localparam int MODE_W = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;

    logic [15:0]       tick_count_reg;
    logic [15:0]       tick_count_next;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              loaded_reg;
    logic              loaded_next;
    logic              switch_now;
    logic [2:0]        row;
    logic [MODE_W-1:0] pick_mode;

    // The lowest column whose running sum exceeds the pick wins, hence the descending scan.
    always_comb
    begin
        row       = 3'(mode_reg);
        pick_mode = '0;
        for (int i = MODE_COUNT - 1; i >= 0; i--)
        begin
            if (uniform_pick < TRANS_CUM[row][3'(i)])
            begin
                pick_mode = MODE_W'(i);
            end
        end
    end

    always_comb
    begin
        switch_now = (tick_count_reg == hold_ticks);
        if (switch_now)
        begin
            tick_count_next = '0;
            mode_next       = pick_mode;
            loaded_next     = 1'b1;
        end
        else
        begin
            tick_count_next = tick_count_reg + 16'd1;
            mode_next       = mode_reg;
            loaded_next     = loaded_reg;
        end
    end

    always_comb
    begin
        mode_out.mode = 3'(mode_next);
        if (loaded_next)
        begin
            mode_out.fast = fast_coef(3'(mode_next));
            mode_out.slow = slow_coef(3'(mode_next));
        end
        else
        begin
            mode_out.fast = '0;
            mode_out.slow = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            mode_reg       <= '0;
            loaded_reg     <= 1'b0;
        end
        else if (accept)
        begin
            tick_count_reg <= tick_count_next;
            mode_reg       <= mode_next;
            loaded_reg     <= loaded_next;
        end
    end

    // Once coefficients are loaded they stay loaded.
    a_loaded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg |=> loaded_reg)
        else $error("coefficient load flag cleared");

    // A mode switch restarts the tick count.
    a_switch_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && switch_now |=> tick_count_reg == 16'd0)
        else $error("tick count not restarted on mode switch");

    // No mode other than the calm one before the first switch.
    a_calm_until_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        !loaded_reg |-> mode_reg == '0)
        else $error("mode moved before the first switch");

endmodule

>>> hw/rtl/mcf_filter.sv
// One second-order noise filter: velocity and level registers with saturation.
module mcf_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mcf_pkg::coef_t      coef,
    input  logic signed [15:0]  noise,
    output logic signed [47:0]  level_next
);
    import mcf_pkg::*;

    logic signed [47:0] vel_reg;
    logic signed [47:0] vel_next;
    logic signed [47:0] lvl_reg;
    logic [16:0]        noise_mag;
    logic [48:0]        drive_prod;
    logic signed [48:0] drive;
    logic signed [48:0] damp_term;
    logic signed [48:0] spring_term;
    logic signed [50:0] vel_sum;
    logic signed [48:0] lvl_sum;

    // x * c / 2^32 truncated toward zero; the 48x32 product is built from two
    // 24x32 partial products.
    function automatic logic signed [48:0] mul_q32(input logic signed [47:0] x,
                                                   input logic [31:0] c);
        logic [47:0] mag;
        logic [55:0] pp_hi;
        logic [55:0] pp_lo;
        logic [79:0] prod;
        logic [48:0] r;
        mag   = x[47] ? (48'd0 - x) : x;
        pp_hi = mag[47:24] * c;
        pp_lo = mag[23:0] * c;
        prod  = {pp_hi, 24'd0} + {24'd0, pp_lo};
        r     = {1'b0, prod[79:32]};
        return x[47] ? $signed(49'd0 - r) : $signed(r);
    endfunction

    // Clamp a wide signed sum to the signed 48-bit state range.
    function automatic logic signed [47:0] sat51(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111)
        begin
            r = v[47:0];
        end
        else if (v[50])
        begin
            r = {1'b1, 47'd0};
        end
        else
        begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        // Q4.12 sample scaled to Q8.40 and multiplied by Q0.32 reduces to |n| * c / 16.
        noise_mag   = noise[15] ? (17'd0 - 17'(noise)) : 17'(noise);
        drive_prod  = noise_mag * coef.scale;
        drive       = noise[15] ? $signed(49'd0 - {4'd0, drive_prod[48:4]})
                                : $signed({4'd0, drive_prod[48:4]});
        damp_term   = mul_q32(vel_reg, coef.damping);
        spring_term = mul_q32(lvl_reg, coef.spring);
        vel_sum     = 51'(vel_reg) + 51'(drive) - 51'(damp_term) - 51'(spring_term);
        vel_next    = sat51(vel_sum);
        lvl_sum     = 49'(lvl_reg) + 49'(vel_next);
        level_next  = sat51(51'(lvl_sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            lvl_reg <= '0;
        end
        else if (accept)
        begin
            vel_reg <= vel_next;
            lvl_reg <= level_next;
        end
    end

endmodule

>>> hw/rtl/mcf_out_buf.sv
// Two-entry output buffer: result register plus skid register.
module mcf_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mcf_pkg::result_t push_result,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output mcf_pkg::result_t out_result
);
    import mcf_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && !out_stall;
    assign full       = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_result;
            end
            else
            begin
                out_data_reg <= push_result;
            end
        end
    end

    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without a result in front");

    // A request arriving behind a stalled result is parked, not dropped.
    a_push_parked: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("request lost behind a stalled result");

    // A parked result stays while the output is stalled.
    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg)
        else $error("parked result lost during stall");

endmodule

>>> hw/rtl/markov_candle_flicker_generator.sv
// Top level of the Markov candle flicker generator.
//
// Each accepted request carries a uniform pick (0 to 99) and two Gaussian samples in
// signed Q4.12, and produces exactly one result: an LED brightness in Q0.16 and the
// Markov mode in force after that tick. The block sustains one request per clock
// cycle while in_stall is low; each result lands in the output or skid register. The
// whole tick (mode choice, both filter updates and the output sum) is combinational
// because each filter's velocity and level feed straight back into the next tick, so
// the path between registers is set by the filter loop: a coefficient select followed
// by two 24x32 partial products per damping and spring term, the velocity sum and
// saturation, then the level sum. A two-entry output buffer lets the block keep
// accepting while one result waits on a stalled consumer; in_stall rises only when
// both entries hold results. Every hold_ticks+1 ticks the current mode's row of the
// transition table picks the next mode; until the first switch all coefficients are
// zero and the brightness equals brightness_offset. The configuration registers
// (hold_ticks at index 0, brightness_offset at index 1) are written through a plain
// write port and should only be changed while no request is in flight.
module markov_candle_flicker_generator #(
    parameter int MODE_COUNT = 5
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write_enable,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [6:0]         uniform_pick,
    input  logic signed [15:0] noise_fast,
    input  logic signed [15:0] noise_slow,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        brightness,
    output logic [2:0]         flicker_mode
);
    import mcf_pkg::*;

    logic               accept;
    logic [15:0]        hold_ticks_reg;
    logic [15:0]        offset_reg;
    mode_out_t          mode_out;
    logic signed [47:0] fast_level;
    logic signed [47:0] slow_level;
    logic signed [49:0] level_sum;
    result_t            new_result;
    result_t            out_result;
    logic               buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
            offset_reg     <= BRIGHTNESS_OFFSET_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_HOLD_TICKS:        hold_ticks_reg <= cfg_data;
                REG_BRIGHTNESS_OFFSET: offset_reg     <= cfg_data;
                default:               hold_ticks_reg <= hold_ticks_reg;
            endcase
        end
    end

    mcf_mode_ctrl #(
        .MODE_COUNT (MODE_COUNT)
    ) u_mode_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .hold_ticks   (hold_ticks_reg),
        .uniform_pick (uniform_pick),
        .mode_out     (mode_out)
    );

    mcf_filter u_fast_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .coef       (mode_out.fast),
        .noise      (noise_fast),
        .level_next (fast_level)
    );

    mcf_filter u_slow_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .coef       (mode_out.slow),
        .noise      (noise_slow),
        .level_next (slow_level)
    );

    // Both levels are Q8.40; the offset is lifted from Q0.16 to the same point. A
    // negative sum clamps to dark, anything at or above 1.0 clamps to full scale.
    always_comb
    begin
        level_sum = 50'(fast_level) + 50'(slow_level) + $signed({10'd0, offset_reg, 24'd0});
        if (level_sum[49])
        begin
            new_result.brightness = 16'd0;
        end
        else if (level_sum[48:40] != 9'd0)
        begin
            new_result.brightness = 16'hFFFF;
        end
        else
        begin
            new_result.brightness = level_sum[39:24];
        end
        new_result.flicker_mode = mode_out.mode;
    end

    mcf_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .push_result (new_result),
        .full        (buf_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (out_result)
    );

    assign brightness   = out_result.brightness;
    assign flicker_mode = out_result.flicker_mode;

    // A delivered mode always lies within the configured number of modes.
    a_mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(flicker_mode) < MODE_COUNT)
        else $error("flicker mode out of range");

    // After an accepted request a result is always valid on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("no result after an accepted request");

    // Requests are refused only while a result is waiting to be taken.
    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with nothing pending");

endmodule
